// File: rtl/uv_sphere_point_generator_core_defines.svh
// Assertion macros for the UV sphere point generator core.
`ifndef UV_SPHERE_POINT_GENERATOR_CORE_DEFINES_SVH
`define UV_SPHERE_POINT_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define UVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define UVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UVS_ASSERT_IMP(lbl, ante, cons, msg)
`define UVS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/uvs_pkg.sv
// Shared constants, types and helper functions for the UV sphere core.
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int DIV_ST  = 10;  // divider stages
  localparam int DIV_PER = 4;   // quotient bits per divider stage
  localparam int TEX_ST  = 5;   // divider stage that closes the 16-bit fraction
  localparam int QW      = 33;  // kept quotient bits
  localparam int TEXW    = 17;

  localparam int COR_ST  = 8;   // CORDIC stages
  localparam int COR_PER = 2;   // micro-rotations per stage
  localparam int CW      = 34;  // CORDIC datapath width

  localparam int S_DIV0  = 1;
  localparam int S_COR0  = S_DIV0 + DIV_ST;
  localparam int S_M1    = S_COR0 + COR_ST;
  localparam int S_M2    = S_M1 + 1;
  localparam int S_OUT   = S_M2 + 1;
  localparam int NST     = S_OUT + 1;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_SUBDIV = 2'd1;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic [8:0]    rem;
    logic [QW-1:0] quo;
  } div_acc_t;

  typedef struct packed {
    logic        pv;
    logic        qv;
    logic [15:0] base;
    logic [15:0] below;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } side_t;

  // arctangent of 2^-i in 2^32-per-turn units
  function automatic logic signed [CW-1:0] atan_turn(input logic [3:0] i);
    logic signed [CW-1:0] a;
    unique case (i)
      4'd0:  a = 34'sd536870912;
      4'd1:  a = 34'sd316933406;
      4'd2:  a = 34'sd167458907;
      4'd3:  a = 34'sd85004756;
      4'd4:  a = 34'sd42667331;
      4'd5:  a = 34'sd21354465;
      4'd6:  a = 34'sd10679838;
      4'd7:  a = 34'sd5340245;
      4'd8:  a = 34'sd2670163;
      4'd9:  a = 34'sd1335087;
      4'd10: a = 34'sd667544;
      4'd11: a = 34'sd333772;
      4'd12: a = 34'sd166886;
      4'd13: a = 34'sd83443;
      4'd14: a = 34'sd41722;
      4'd15: a = 34'sd20861;
    endcase
    return a;
  endfunction

  // one restoring division step
  function automatic div_acc_t div_iter(input div_acc_t a, input logic b,
                                        input logic [7:0] n);
    logic [9:0] t;
    div_acc_t   r;
    t = {a.rem, b};
    if (t >= {2'b00, n}) begin
      r.rem = 9'(t - {2'b00, n});
      r.quo = {a.quo[QW-2:0], 1'b1};
    end else begin
      r.rem = t[8:0];
      r.quo = {a.quo[QW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: rtl/uvs_div.sv
// Pipelined restoring divider: step * 2^32 / n, plus rounded step * 2^16 / n.
`timescale 1ns / 1ps
module uvs_div import uvs_pkg::*; (
  input  logic              clk,
  input  logic [DIV_ST-1:0] en,
  input  logic [7:0]        step_i,
  input  logic [7:0]        n,
  output logic [QW-1:0]     quo_o,
  output logic [TEXW-1:0]   tex_o
);

  div_acc_t        acc_r   [DIV_ST];
  div_acc_t        acc_nxt [DIV_ST];
  logic [7:0]      step_r  [DIV_ST];
  logic [7:0]      step_nxt[DIV_ST];
  logic [TEXW-1:0] tex_r   [DIV_ST];
  logic [TEXW-1:0] tex_nxt [DIV_ST];

  for (genvar s = 0; s < DIV_ST; s++) begin : g_st
    // previous stage; stage 0 never reads it
    localparam int PRV = (s == 0) ? 0 : s - 1;

    always_comb begin
      div_acc_t   a;
      logic [7:0] sh;
      logic [9:0] rr;
      if (s == 0) begin
        a  = '0;
        sh = step_i;
      end else begin
        a  = acc_r[PRV];
        sh = step_r[PRV];
      end
      // dividend bits are the step msb first, then zeros
      for (int j = 0; j < DIV_PER; j++) begin
        a  = div_iter(a, sh[7], n);
        sh = {sh[6:0], 1'b0};
      end
      acc_nxt[s]  = a;
      step_nxt[s] = sh;
      rr = {1'b0, a.rem} + {3'b000, n[7:1]};
      if (s == TEX_ST) begin
        tex_nxt[s] = a.quo[TEXW-1:0] + TEXW'(rr >= {2'b00, n});
      end else if (s > TEX_ST) begin
        tex_nxt[s] = tex_r[PRV];
      end else begin
        tex_nxt[s] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        acc_r[s]  <= acc_nxt[s];
        step_r[s] <= step_nxt[s];
        tex_r[s]  <= tex_nxt[s];
      end
    end
  end

  assign quo_o = acc_r[DIV_ST-1].quo;
  assign tex_o = tex_r[DIV_ST-1];

endmodule

// File: rtl/uvs_cordic.sv
// Pipelined 16-step CORDIC: sine and cosine of a 2^32-per-turn phase at 2^30.
`timescale 1ns / 1ps
module uvs_cordic import uvs_pkg::*; (
  input  logic               clk,
  input  logic [COR_ST-1:0]  en,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic signed [CW-1:0] x_r  [COR_ST];
  logic signed [CW-1:0] y_r  [COR_ST];
  logic signed [CW-1:0] z_r  [COR_ST];
  logic [1:0]           q_r  [COR_ST];
  logic signed [CW-1:0] x_nxt[COR_ST];
  logic signed [CW-1:0] y_nxt[COR_ST];
  logic signed [CW-1:0] z_nxt[COR_ST];
  logic [1:0]           q_nxt[COR_ST];

  for (genvar s = 0; s < COR_ST; s++) begin : g_st
    // previous stage; stage 0 never reads it
    localparam int PRV = (s == 0) ? 0 : s - 1;

    always_comb begin
      logic signed [CW-1:0] x, y, z, dx, dy;
      logic [1:0]           q;
      if (s == 0) begin
        x = CORDIC_X0;
        y = '0;
        z = $signed({4'b0000, phase_i[29:0]});
        q = phase_i[31:30];
      end else begin
        x = x_r[PRV];
        y = y_r[PRV];
        z = z_r[PRV];
        q = q_r[PRV];
      end
      for (int j = 0; j < COR_PER; j++) begin
        dx = y >>> (s * COR_PER + j);
        dy = x >>> (s * COR_PER + j);
        if (!z[CW-1]) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_turn(4'(s * COR_PER + j));
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_turn(4'(s * COR_PER + j));
        end
      end
      // last stage folds in the quadrant: y carries sine, x cosine
      if (s == COR_ST - 1) begin
        unique case (q)
          2'd0: begin x_nxt[s] = x;  y_nxt[s] = y;  end
          2'd1: begin x_nxt[s] = -y; y_nxt[s] = x;  end
          2'd2: begin x_nxt[s] = -x; y_nxt[s] = -y; end
          2'd3: begin x_nxt[s] = y;  y_nxt[s] = -x; end
        endcase
      end else begin
        x_nxt[s] = x;
        y_nxt[s] = y;
      end
      z_nxt[s] = z;
      q_nxt[s] = q;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        x_r[s] <= x_nxt[s];
        y_r[s] <= y_nxt[s];
        z_r[s] <= z_nxt[s];
        q_r[s] <= q_nxt[s];
      end
    end
  end

  assign sin_o = $signed(y_r[COR_ST-1][31:0]);
  assign cos_o = $signed(x_r[COR_ST-1][31:0]);

endmodule

// File: rtl/uv_sphere_point_generator_core.sv
// UV sphere grid point generator: takes one (lat_step, lon_step) word per
// clock while in_ready is high and returns the vertex normal (Q1.15),
// radius-scaled position (Q8.8), texture coordinates (Q1.16) and quad
// indices. Throughput is one word per cycle unless the output stalls; a word
// passes 22 register stages: the range check and quad index stage, the
// ten-stage restoring divider (four quotient bits per stage) that turns the
// steps into phases, the eight-stage CORDIC (two rotations per stage) and
// three multiply/round stages. Each stage holds its word until the next
// stage is free, so a stall on the output backs up the pipe without
// dropping or repeating words. The user must write registers only while the
// pipe is empty; the block does not enforce it. Zero subdivisions act as one.
`timescale 1ns / 1ps
`include "uv_sphere_point_generator_core_defines.svh"
module uv_sphere_point_generator_core import uvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input word
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_lat_step,
  input  logic [7:0]         in_lon_step,
  // result word
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_point_valid,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic               out_quad_valid,
  output logic [15:0]        out_quad_base_index,
  output logic [15:0]        out_quad_below_index
);

  // saturate a rounded value to Q1.15
  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767)       r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [15:0] radius_r;
  logic [7:0]  subdiv_r;
  logic [7:0]  n_clamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      subdiv_r <= 8'd16;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_data;
        CFG_SUBDIV: subdiv_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign n_clamp = (subdiv_r == 8'd0) ? 8'd1 : subdiv_r;

  // ---------------- stage control ----------------
  // A stage moves on when it is empty or the stage after it moves on.
  logic [NST-1:0] valid_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !valid_r[NST-1] || out_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !valid_r[s] || en[s+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          valid_r[s] <= valid_r[s-1];
        end
      end
    end
  end

  // ---------------- stage 0: range check, quad indices ----------------
  logic [7:0]  lat_r, lon_r;
  side_t       side_r  [NST];
  side_t       side_nxt[NST];
  logic [16:0] base_full;

  always_comb begin
    // lat * (n + 1) + lon
    base_full   = ({9'd0, in_lat_step} * {9'd0, n_clamp})
                + 17'({9'd0, in_lat_step}) + 17'({9'd0, in_lon_step});
    side_nxt[0] = '0;
    side_nxt[0].pv = (in_lat_step <= n_clamp) && (in_lon_step <= n_clamp);
    side_nxt[0].qv = (in_lat_step < n_clamp) && (in_lon_step < n_clamp);
    if (side_nxt[0].qv) begin
      side_nxt[0].base  = base_full[15:0];
      side_nxt[0].below = base_full[15:0] + {8'd0, n_clamp} + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lat_r     <= in_lat_step;
      lon_r     <= in_lon_step;
      side_r[0] <= side_nxt[0];
    end
  end

  // ---------------- dividers: step / n as phase and texture ----------------
  logic [QW-1:0]   lat_quo, lon_quo;
  logic [TEXW-1:0] lat_tex, lon_tex;

  uvs_div u_div_lat (
    .clk    (clk),
    .en     (en[S_DIV0 +: DIV_ST]),
    .step_i (lat_r),
    .n      (n_clamp),
    .quo_o  (lat_quo),
    .tex_o  (lat_tex)
  );

  uvs_div u_div_lon (
    .clk    (clk),
    .en     (en[S_DIV0 +: DIV_ST]),
    .step_i (lon_r),
    .n      (n_clamp),
    .quo_o  (lon_quo),
    .tex_o  (lon_tex)
  );

  // side data rides along; texture joins once the dividers are done
  for (genvar s = 1; s < NST; s++) begin : g_side
    always_comb begin
      side_nxt[s] = side_r[s-1];
      if (s == S_COR0) begin
        side_nxt[s].tex_u = side_r[s-1].pv ? lon_tex : '0;
        side_nxt[s].tex_v = side_r[s-1].pv ? lat_tex : '0;
      end
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        side_r[s] <= side_nxt[s];
      end
    end
  end

  // ---------------- CORDIC: theta = half turn scale, phi = full turn ----------------
  logic signed [31:0] sin_t, cos_t, sin_p, cos_p;

  uvs_cordic u_cor_theta (
    .clk     (clk),
    .en      (en[S_COR0 +: COR_ST]),
    .phase_i (lat_quo[32:1]),
    .sin_o   (sin_t),
    .cos_o   (cos_t)
  );

  uvs_cordic u_cor_phi (
    .clk     (clk),
    .en      (en[S_COR0 +: COR_ST]),
    .phase_i (lon_quo[31:0]),
    .sin_o   (sin_p),
    .cos_o   (cos_p)
  );

  // ---------------- M1: products ----------------
  logic signed [63:0] prod_x_r, prod_z_r;
  logic signed [15:0] ny1_r;
  logic signed [63:0] ct_ext;

  assign ct_ext = 64'(cos_t) + 64'sd16384;

  always_ff @(posedge clk) begin
    if (en[S_M1]) begin
      prod_x_r <= 64'(cos_p) * 64'(sin_t);
      prod_z_r <= 64'(sin_p) * 64'(sin_t);
      ny1_r    <= sat16(ct_ext >>> 15);
    end
  end

  // ---------------- M2: round products to Q1.15 ----------------
  logic signed [15:0] nx2_r, ny2_r, nz2_r;
  localparam logic signed [63:0] HALF45 = 64'sd1 <<< 44;

  always_ff @(posedge clk) begin
    if (en[S_M2]) begin
      nx2_r <= sat16((prod_x_r + HALF45) >>> 45);
      ny2_r <= ny1_r;
      nz2_r <= sat16((prod_z_r + HALF45) >>> 45);
    end
  end

  // ---------------- M3: scale by radius, output register ----------------
  logic signed [15:0] nx_r, ny_r, nz_r;
  logic signed [16:0] px_r, py_r, pz_r;
  logic signed [16:0] rad_s;
  logic signed [33:0] px_full, py_full, pz_full;
  logic               pv_m;

  assign rad_s   = $signed({1'b0, radius_r});
  assign px_full = (34'(rad_s) * 34'(nx2_r) + 34'sd16384) >>> 15;
  assign py_full = (34'(rad_s) * 34'(ny2_r) + 34'sd16384) >>> 15;
  assign pz_full = (34'(rad_s) * 34'(nz2_r) + 34'sd16384) >>> 15;
  assign pv_m    = side_r[S_M2].pv;

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      nx_r <= pv_m ? nx2_r : '0;
      ny_r <= pv_m ? ny2_r : '0;
      nz_r <= pv_m ? nz2_r : '0;
      px_r <= pv_m ? $signed(px_full[16:0]) : '0;
      py_r <= pv_m ? $signed(py_full[16:0]) : '0;
      pz_r <= pv_m ? $signed(pz_full[16:0]) : '0;
    end
  end

  assign out_point_valid      = side_r[S_OUT].pv;
  assign out_normal_x         = nx_r;
  assign out_normal_y         = ny_r;
  assign out_normal_z         = nz_r;
  assign out_pos_x            = px_r;
  assign out_pos_y            = py_r;
  assign out_pos_z            = pz_r;
  assign out_tex_u            = side_r[S_OUT].tex_u;
  assign out_tex_v            = side_r[S_OUT].tex_v;
  assign out_quad_valid       = side_r[S_OUT].qv;
  assign out_quad_base_index  = side_r[S_OUT].base;
  assign out_quad_below_index = side_r[S_OUT].below;

  // ---------------- checks ----------------
  `UVS_ASSERT_IMP(a_inval_zero, out_valid && !out_point_valid, !out_quad_valid && out_tex_u == 17'd0 && out_pos_x == 17'sd0, "invalid point word not cleared")
  `UVS_ASSERT_IMP(a_quad_in_range, out_valid && out_quad_valid, out_point_valid, "quad flagged on out-of-range point")
  `UVS_ASSERT_IMP(a_stall_full, !in_ready, (&valid_r) && !out_ready, "input stalled with room in pipe")
  `UVS_ASSERT_NXT(a_no_phantom, !valid_r[NST-2] && !out_valid, !out_valid, "output word from empty stage")

endmodule

// File: dv/uv_sphere_point_generator_core_tb.sv
// Self-checking testbench for the UV sphere point generator core.
`timescale 1ns / 1ps
module uv_sphere_point_generator_core_tb;
  import uvs_pkg::*;

  // One result word as the block presents it.
  typedef struct {
    logic               pv;
    logic signed [15:0] nx, ny, nz;
    logic signed [16:0] px, py, pz;
    logic [16:0]        tu, tv;
    logic               qv;
    logic [15:0]        base, below;
  } vertex_t;

  int errors = 0;

  // Prints one line per mismatch and counts it.
  task automatic report(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Expected-vertex store; the predictor keeps its own copy of the registers.
  class vertex_scoreboard;
    logic [15:0] radius_r = 16'd256;
    logic [7:0]  bands_r = 8'd16;
    vertex_t     pending[$];

    static const longint ATAN[16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

    static function longint fshr(input longint v, input int s);
      return v >>> s;
    endfunction

    static function longint rsat(input longint v, input int s);
      longint r;
      r = fshr(v + (longint'(1) << (s - 1)), s);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    // Sine and cosine at scale 2^30 of a 2^32-per-turn phase.
    static function void turn_sincos(input logic [31:0] p, output longint sn,
                                     output longint cs);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'(p[29:0]);
      for (int i = 0; i < 16; i++) begin
        dx = fshr(y, i);
        dy = fshr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN[i];
        end else begin
          x += dx; y -= dy; z += ATAN[i];
        end
      end
      case (p[31:30])
        2'd0: begin sn = y;  cs = x;  end
        2'd1: begin sn = x;  cs = -y; end
        2'd2: begin sn = -y; cs = -x; end
        default: begin sn = -x; cs = y; end
      endcase
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [15:0] d);
      if (idx == CFG_RADIUS) radius_r = d;
      else if (idx == CFG_SUBDIV) bands_r = d[7:0];
    endfunction

    function void note_input(input logic [7:0] lat, input logic [7:0] lon);
      vertex_t v;
      longint unsigned n, b;
      longint st, ct, sp, cp, nv[3], ps[3];
      logic [31:0] tp, pp;
      v = '{default: '0};
      n = (bands_r == 0) ? 1 : bands_r;
      if (lat <= n && lon <= n) begin
        tp = 32'((longint'(lat) << 31) / n);
        pp = 32'((longint'(lon) << 32) / n);
        turn_sincos(tp, st, ct);
        turn_sincos(pp, sp, cp);
        nv[0] = rsat(cp * st, 45);
        nv[1] = rsat(ct, 15);
        nv[2] = rsat(sp * st, 45);
        for (int k = 0; k < 3; k++)
          ps[k] = fshr(longint'(radius_r) * nv[k] + 16384, 15);
        v.pv = 1'b1;
        v.nx = 16'(nv[0]); v.ny = 16'(nv[1]); v.nz = 16'(nv[2]);
        v.px = 17'(ps[0]); v.py = 17'(ps[1]); v.pz = 17'(ps[2]);
        v.tu = 17'(((longint'(lon) << 16) + n / 2) / n);
        v.tv = 17'(((longint'(lat) << 16) + n / 2) / n);
        if (lat < n && lon < n) begin
          b = lat * (n + 1) + lon;
          v.qv = 1'b1;
          v.base = 16'(b);
          v.below = 16'(b + n + 1);
        end
      end
      pending.insert(pending.size(), v);
    endfunction

    task check_output(input vertex_t got);
      vertex_t e;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.pv !== e.pv) report($sformatf("point_valid %0d exp %0d", got.pv, e.pv));
      if (got.nx !== e.nx) report($sformatf("normal_x %0d exp %0d", got.nx, e.nx));
      if (got.ny !== e.ny) report($sformatf("normal_y %0d exp %0d", got.ny, e.ny));
      if (got.nz !== e.nz) report($sformatf("normal_z %0d exp %0d", got.nz, e.nz));
      if (got.px !== e.px) report($sformatf("pos_x %0d exp %0d", got.px, e.px));
      if (got.py !== e.py) report($sformatf("pos_y %0d exp %0d", got.py, e.py));
      if (got.pz !== e.pz) report($sformatf("pos_z %0d exp %0d", got.pz, e.pz));
      if (got.tu !== e.tu) report($sformatf("tex_u %0d exp %0d", got.tu, e.tu));
      if (got.tv !== e.tv) report($sformatf("tex_v %0d exp %0d", got.tv, e.tv));
      if (got.qv !== e.qv) report($sformatf("quad_valid %0d exp %0d", got.qv, e.qv));
      if (got.base !== e.base) report($sformatf("base %0d exp %0d", got.base, e.base));
      if (got.below !== e.below)
        report($sformatf("below %0d exp %0d", got.below, e.below));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_lat_step = '0, in_lon_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_point_valid, out_quad_valid;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic signed [16:0] out_pos_x, out_pos_y, out_pos_z;
  logic [16:0] out_tex_u, out_tex_v;
  logic [15:0] out_quad_base_index, out_quad_below_index;

  vertex_scoreboard sb = new();
  bit stim_done = 1'b0;

  always #6 clk = ~clk;

  uv_sphere_point_generator_core uut (.*);

  // Presents one step word after a random gap, and holds it until taken.
  // Valid stays high into the next word when there is no gap.
  task automatic send_point(input logic [7:0] lat, input logic [7:0] lon);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lat_step <= lat;
    in_lon_step <= lon;
    do @(posedge clk); while (!in_ready);
    sb.note_input(lat, lon);
  endtask

  // Register writes only with the pipe drained.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  // Mostly in-range steps, with some beyond N and some full-range noise.
  task automatic random_phase(input int count);
    int n;
    logic [7:0] la, lo;
    n = (sb.bands_r == 0) ? 1 : sb.bands_r;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin la = 8'($urandom); lo = 8'($urandom); end
        1: begin la = 8'(n); lo = 8'($urandom_range(0, n)); end
        2: begin
          la = 8'($urandom_range(0, n));
          lo = 8'((n < 255) ? n + 1 : n);
        end
        default: begin
          la = 8'($urandom_range(0, n));
          lo = 8'($urandom_range(0, n));
        end
      endcase
      send_point(la, lo);
    end
  endtask

  // Receiver: random stalls, with runs of no stall.
  always @(posedge clk) begin
    vertex_t got;
    if (rst_n && out_valid && out_ready) begin
      got.pv = out_point_valid;
      got.nx = out_normal_x; got.ny = out_normal_y; got.nz = out_normal_z;
      got.px = out_pos_x; got.py = out_pos_y; got.pz = out_pos_z;
      got.tu = out_tex_u; got.tv = out_tex_v;
      got.qv = out_quad_valid;
      got.base = out_quad_base_index;
      got.below = out_quad_below_index;
      sb.check_output(got);
    end
  end

  initial begin
    int wait_n;
    @(posedge clk);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed corners at reset settings (R = 1.0, N = 16).
    send_point(0, 0);
    send_point(16, 16);
    send_point(8, 4);
    send_point(15, 15);
    send_point(16, 3);
    send_point(3, 16);
    send_point(17, 0);
    send_point(0, 17);
    send_point(255, 255);
    send_point(8'hAA, 8'h55);
    send_point(8'h55, 8'hAA);
    write_reg(CFG_SUBDIV, 16'h0000);  // zero bands act as one
    send_point(0, 0);
    send_point(1, 1);
    send_point(0, 1);
    send_point(2, 0);
    write_reg(CFG_SUBDIV, 16'h00FF);
    write_reg(CFG_RADIUS, 16'hFFFF);
    send_point(255, 255);
    send_point(254, 254);
    send_point(128, 64);
    send_point(0, 255);
    write_reg(2'd2, 16'h1234);        // unused index, ignored
    write_reg(2'd3, 16'hFFFF);
    send_point(100, 200);
    // Random phases over several settings, extremes included.
    write_reg(CFG_RADIUS, 16'h0000);
    write_reg(CFG_SUBDIV, 16'h0003);
    random_phase(200);
    write_reg(CFG_RADIUS, 16'hFFFF);
    write_reg(CFG_SUBDIV, 16'h0001);
    random_phase(150);
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_RADIUS, 16'($urandom));
      write_reg(CFG_SUBDIV,
                (ph == 7) ? (16'hFF00 | 16'd255) : 16'($urandom_range(1, 255)));
      random_phase(210);
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
